FILE: rtl/ces_pkg.sv
// Shared types and constants for the countdown event scheduler.
// Used by ces_timer, countdown_event_scheduler and the bench; no dependencies.
package ces_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ADD   = 3'd1,
    OP_LOAD  = 3'd2,
    OP_MINS  = 3'd3,
    OP_PAUSE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_TK_RD,
    ST_TK_CMP,
    ST_INS_RD,
    ST_INS_LOOP,
    ST_INS_HEAD
  } state_e;

  // command from the control path to the countdown unit
  typedef struct packed {
    logic                     valid;
    op_e                      op;
    logic signed [TIME_W-1:0] value;
  } timer_cmd_t;

  // one queue entry
  typedef struct packed {
    logic signed [TIME_W-1:0] trig;
    logic [ID_BITS-1:0]       id;
  } entry_t;

  // circular pointer add, modulo QUEUE_DEPTH (operands below QUEUE_DEPTH)
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                               input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/ces_timer.sv
// Countdown register and pause flag with saturating tick/minutes arithmetic.
// Depends on ces_pkg.
module ces_timer (
  input  logic                               clk,
  input  logic                               rst,
  input  ces_pkg::timer_cmd_t                cmd,
  output logic signed [ces_pkg::TIME_W-1:0]  countdown,
  output logic                               paused
);

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic signed [32:0] diff;
  logic signed [37:0] prod;
  logic signed [31:0] diff_sat;
  logic signed [31:0] prod_sat;
  logic signed [31:0] countdown_next;
  logic               paused_next;

  always_comb begin
    diff = {countdown[31], countdown} - {cmd.value[31], cmd.value};
    // minutes times 60 as (v << 6) - (v << 2)
    prod = ({{6{cmd.value[31]}}, cmd.value} <<< 6) - ({{6{cmd.value[31]}}, cmd.value} <<< 2);

    if (diff[32] != diff[31]) begin
      diff_sat = diff[32] ? SMIN : SMAX;
    end else begin
      diff_sat = diff[31:0];
    end

    if ((prod[37:31] != 7'h00) && (prod[37:31] != 7'h7F)) begin
      prod_sat = prod[37] ? SMIN : SMAX;
    end else begin
      prod_sat = prod[31:0];
    end

    countdown_next = countdown;
    paused_next    = paused;
    if (cmd.valid) begin
      unique case (cmd.op)
        ces_pkg::OP_TICK:  if (!paused) countdown_next = diff_sat;
        ces_pkg::OP_LOAD:  countdown_next = cmd.value;
        ces_pkg::OP_MINS:  countdown_next = prod_sat;
        ces_pkg::OP_PAUSE: paused_next = !paused;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
      paused    <= 1'b0;
    end else begin
      countdown <= countdown_next;
      paused    <= paused_next;
    end
  end

endmodule

FILE: rtl/countdown_event_scheduler.sv
// Countdown event scheduler: one item at a time. Non-tick ops and paused ticks answer from ST_RESP.
// Add: walks from the tail, shifting entries at or below the new time; an empty queue writes the head.
// Tick: ST_TK_RD reads the head, ST_TK_CMP tests the registered read data; repeats while entries fire.
// Next beat accepted once the last result beat is loaded into the output register.
// Reset clears countdown, pause, queue count and head; queue memory contents are not cleared.
// Depends on ces_pkg and ces_timer.
module countdown_event_scheduler (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] time_value, [39:32] event_id
  input  logic [2:0]  s_tuser,   // [2:0] op
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] fired_id, [8] accepted, [40:9] remaining, [47:41] zero
  output logic        m_tuser,   // [0] fired
  output logic        m_tlast
);

  localparam int PW = ces_pkg::PTR_W;
  localparam int CW = ces_pkg::CNT_W;
  localparam int IW = ces_pkg::ID_BITS;

  // ---------------------------------------------------------------
  // Countdown unit
  // ---------------------------------------------------------------
  ces_pkg::timer_cmd_t                 tcmd;
  logic signed [ces_pkg::TIME_W-1:0]   countdown;
  logic                                paused;
  logic                                in_beat;
  ces_pkg::op_e                        in_op;

  assign in_beat    = s_tvalid && s_tready;
  assign in_op      = ces_pkg::op_e'(s_tuser);
  assign tcmd.valid = in_beat;
  assign tcmd.op    = in_op;
  assign tcmd.value = s_tdata[31:0];

  ces_timer u_timer (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tcmd),
    .countdown (countdown),
    .paused    (paused)
  );

  // ---------------------------------------------------------------
  // Queue memory: circular buffer, logical slot 0 at head holds the
  // highest trigger time. One write and one registered read per cycle.
  // ---------------------------------------------------------------
  ces_pkg::entry_t mem [ces_pkg::QUEUE_DEPTH];
  ces_pkg::entry_t rdata;
  logic            mem_we;
  logic [PW-1:0]   mem_waddr;
  ces_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [PW-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  ces_pkg::state_e  state, state_next;
  logic [PW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [PW-1:0]    j, j_next;              // logical slot being read in insert walk
  logic             acc, acc_next;
  logic             have_prev, have_prev_next;  // a fired event waits for its last flag
  logic [IW-1:0]    prev_id, prev_id_next;
  ces_pkg::entry_t  new_ent;                // event being inserted

  logic             out_free;
  logic             emit;
  logic             emit_fired;
  logic [IW-1:0]    emit_id;
  logic             emit_last;
  logic             fires;
  ces_pkg::entry_t  in_ent;

  assign out_free    = !m_tvalid || m_tready;
  assign fires       = (countdown <= rdata.trig);
  assign in_ent.trig = s_tdata[31:0];
  assign in_ent.id   = IW'(s_tdata[39:32]);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    j_next         = j;
    acc_next       = acc;
    have_prev_next = have_prev;
    prev_id_next   = prev_id;
    s_tready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = head;
    mem_wdata      = new_ent;
    mem_re         = 1'b0;
    mem_raddr      = head;
    emit           = 1'b0;
    emit_fired     = 1'b0;
    emit_id        = '0;
    emit_last      = 1'b1;

    unique case (state)
      ces_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          acc_next       = 1'b1;
          have_prev_next = 1'b0;
          state_next     = ces_pkg::ST_RESP;
          if (in_op == ces_pkg::OP_TICK && !paused) begin
            state_next = ces_pkg::ST_TK_RD;
          end else if (in_op == ces_pkg::OP_ADD) begin
            if (count == CW'(ces_pkg::QUEUE_DEPTH)) begin
              acc_next = 1'b0;
            end else begin
              state_next = ces_pkg::ST_INS_RD;
            end
          end
        end
      end

      ces_pkg::ST_RESP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ces_pkg::ST_IDLE;
        end
      end

      // fetch the head entry, or finish when the queue ran empty
      ces_pkg::ST_TK_RD: begin
        if (count == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_fired = have_prev;
            emit_id    = have_prev ? prev_id : '0;
            state_next = ces_pkg::ST_IDLE;
          end
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = head;
          state_next = ces_pkg::ST_TK_CMP;
        end
      end

      // head entry in rdata; a held fire gets last = 0 only if this one fires too
      ces_pkg::ST_TK_CMP: begin
        if (fires) begin
          if (!have_prev || out_free) begin
            emit           = have_prev;
            emit_fired     = 1'b1;
            emit_id        = prev_id;
            emit_last      = 1'b0;
            prev_id_next   = rdata.id;
            have_prev_next = 1'b1;
            head_next      = ces_pkg::ptr_add(head, PW'(1));
            count_next     = count - 1'b1;
            state_next     = ces_pkg::ST_TK_RD;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          emit_fired = have_prev;
          emit_id    = have_prev ? prev_id : '0;
          state_next = ces_pkg::ST_IDLE;
        end
      end

      // start the walk from the tail toward the head
      ces_pkg::ST_INS_RD: begin
        if (count == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = head;
          count_next = count + 1'b1;
          state_next = ces_pkg::ST_RESP;
        end else begin
          j_next     = PW'(count - 1'b1);
          mem_re     = 1'b1;
          mem_raddr  = ces_pkg::ptr_add(head, PW'(count - 1'b1));
          state_next = ces_pkg::ST_INS_LOOP;
        end
      end

      // slot j in rdata: shift it down one, or drop the new entry behind it
      ces_pkg::ST_INS_LOOP: begin
        mem_we    = 1'b1;
        mem_waddr = ces_pkg::ptr_add(head, j + 1'b1);
        if (rdata.trig > new_ent.trig) begin
          count_next = count + 1'b1;
          state_next = ces_pkg::ST_RESP;
        end else begin
          mem_wdata = rdata;
          if (j == '0) begin
            state_next = ces_pkg::ST_INS_HEAD;
          end else begin
            j_next    = j - 1'b1;
            mem_re    = 1'b1;
            mem_raddr = ces_pkg::ptr_add(head, j - 1'b1);
          end
        end
      end

      ces_pkg::ST_INS_HEAD: begin
        mem_we     = 1'b1;
        mem_waddr  = head;
        count_next = count + 1'b1;
        state_next = ces_pkg::ST_RESP;
      end

      default: state_next = ces_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ces_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      have_prev <= have_prev_next;
    end
  end

  always_ff @(posedge clk) begin
    j       <= j_next;
    acc     <= acc_next;
    prev_id <= prev_id_next;
    if (in_beat) begin
      new_ent <= in_ent;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'd0, countdown, acc, 8'(emit_id)};
      m_tuser <= emit_fired;
      m_tlast <= emit_last;
    end
  end

endmodule

FILE: bench/ces_checker.sv
// Scoreboard for the countdown event scheduler: watches both stream ports,
// keeps its own copy of the countdown and the sorted event queue, and compares beats.
// Depends on ces_pkg.
module ces_checker
  import ces_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                     fired;
    logic [7:0]               fired_id;
    logic                     accepted;
    logic signed [TIME_W-1:0] remaining;
    logic                     last;
  } sched_beat_t;

  sched_beat_t due_beats[$];

  logic signed [TIME_W-1:0] cd;
  logic                     halted;
  logic signed [TIME_W-1:0] trig_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       id_q   [QUEUE_DEPTH];
  int                       n_pend;

  function automatic logic signed [TIME_W-1:0] clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'd2147483648)) return 32'sh8000_0000;
    return v[TIME_W-1:0];
  endfunction

  // advance the scheduler copy by one command and queue the beats it owes
  task automatic apply_op(input logic [2:0] op, input logic signed [TIME_W-1:0] tv,
                          input logic [7:0] id);
    sched_beat_t b;
    int          pos;
    int          fires;
    logic        acc;
    fires = 0;
    acc   = 1'b1;
    case (op)
      OP_TICK: begin
        if (!halted) begin
          cd = clamp32(longint'(cd) - longint'(tv));
          while (n_pend > 0 && cd <= trig_q[0]) begin
            b.fired    = 1'b1;
            b.fired_id = 8'(id_q[0]);
            b.accepted = 1'b1;
            b.remaining = cd;
            b.last     = 1'b0;
            for (int i = 0; i < n_pend - 1; i++) begin
              trig_q[i] = trig_q[i+1];
              id_q[i]   = id_q[i+1];
            end
            n_pend--;
            due_beats.push_back(b);
            fires++;
          end
        end
      end
      OP_ADD: begin
        if (n_pend >= QUEUE_DEPTH) begin
          acc = 1'b0;
        end else begin
          pos = 0;
          // new entry goes ahead of equal times
          while (pos < n_pend && trig_q[pos] > tv) pos++;
          for (int i = n_pend; i > pos; i--) begin
            trig_q[i] = trig_q[i-1];
            id_q[i]   = id_q[i-1];
          end
          trig_q[pos] = tv;
          id_q[pos]   = id[ID_BITS-1:0];
          n_pend++;
        end
      end
      OP_LOAD:  cd = tv;
      OP_MINS:  cd = clamp32(longint'(tv) * 60);
      OP_PAUSE: halted = !halted;
      default: ;
    endcase
    if (fires > 0) begin
      due_beats[due_beats.size()-1].last = 1'b1;
    end else begin
      b.fired     = 1'b0;
      b.fired_id  = 8'd0;
      b.accepted  = acc;
      b.remaining = cd;
      b.last      = 1'b1;
      due_beats.push_back(b);
    end
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat();
    sched_beat_t b;
    if (due_beats.size() == 0) begin
      $error("result beat with nothing pending: tdata %h tuser %b tlast %b",
             m_tdata, m_tuser, m_tlast);
      errors++;
    end else begin
      b = due_beats.pop_front();
      cmp_field("fired", b.fired, m_tuser);
      cmp_field("fired_id", b.fired_id, m_tdata[7:0]);
      cmp_field("accepted", b.accepted, m_tdata[8]);
      cmp_field("remaining", b.remaining, $signed(m_tdata[40:9]));
      cmp_field("last", b.last, m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cd     = '0;
      halted = 1'b0;
      n_pend = 0;
      errors = 0;
      due_beats.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready) apply_op(s_tuser, s_tdata[31:0], s_tdata[39:32]);
    end
    outstanding = due_beats.size();
  end

endmodule

FILE: bench/countdown_event_scheduler_tb.sv
// Top of the countdown event scheduler bench: clock, reset, command stimulus,
// output back-pressure and the final verdict. Depends on ces_pkg, ces_checker
// and countdown_event_scheduler.
module countdown_event_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ces_pkg::*;

  localparam int RAND_ITEMS     = 300;
  localparam int RX_HOLD_CYCLES = 300;  // long receiver hold, fills the block
  localparam int END_SETTLE     = 60;   // settle time after the final drain, beyond the longest tick

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int   errors;
  int   outstanding;
  int   sent        = 0;
  int   tx_calm     = 0;     // items left in a gap-free burst
  logic paused_now  = 1'b0;  // our own view of the pause toggle
  logic hold_rx     = 1'b0;  // request for one long receiver stall

  countdown_event_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  ces_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender idle gaps: mostly none or short, a few long, plus gap-free bursts.
  function automatic int pick_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      tx_calm = $urandom_range(30, 10);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one command beat and hold it until accepted. Called at a rising
  // edge; valid stays up afterwards so back-to-back beats need no toggle.
  task automatic send_cmd(input logic [2:0] op, input logic [31:0] tv,
                          input logic [7:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {id, tv};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
    if (op == OP_PAUSE) paused_now = !paused_now;
  endtask

  // Stop offering and wait until every predicted beat has come out.
  // Sampled on the falling edge so the checker's update is settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic resume_if_paused();
    if (paused_now) send_cmd(OP_PAUSE, $urandom, 8'($urandom));
  endtask

  // Well-formed run: set a countdown, queue events below it (some equal,
  // some above), then tick it down so they fire, sometimes with a pause in between.
  task automatic countdown_run();
    int base;
    int mins;
    int nev;
    int t;
    int nticks;
    resume_if_paused();
    if ($urandom_range(1)) begin
      mins = $urandom_range(3000, 16);
      base = mins * 60;
      send_cmd(OP_MINS, mins, 8'($urandom));
    end else begin
      base = $urandom_range(200000, 1000);
      send_cmd(OP_LOAD, base, 8'($urandom));
    end
    nev = ($urandom_range(4) == 0) ? $urandom_range(18, 14) : $urandom_range(6, 1);
    t = $urandom_range(base);
    repeat (nev) begin
      // keep the previous time now and then to exercise tie ordering
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(9) == 0) t = base + $urandom_range(5000);
        else t = $urandom_range(base);
      end
      send_cmd(OP_ADD, t, 8'($urandom));
    end
    nticks = $urandom_range(8, 2);
    repeat (nticks) begin
      if ($urandom_range(9) == 0) begin
        send_cmd(OP_PAUSE, $urandom, 8'($urandom));
        send_cmd(OP_TICK, $urandom_range(base / 3), 8'($urandom));
        send_cmd(OP_PAUSE, $urandom, 8'($urandom));
      end
      send_cmd(OP_TICK, $urandom_range(base / 3), 8'($urandom));
    end
    // flush whatever is left half the time
    if ($urandom_range(1)) send_cmd(OP_TICK, 32'h7FFF_FFFF, 8'($urandom));
  endtask

  // Overfill the queue with arbitrary times, then drive the countdown to the
  // floor so every entry fires.
  task automatic fill_and_flush();
    int nev;
    resume_if_paused();
    nev = $urandom_range(20, 16);
    repeat (nev) send_cmd(OP_ADD, $urandom, 8'($urandom));
    send_cmd(OP_TICK, 32'h7FFF_FFFF, 8'($urandom));
    send_cmd(OP_TICK, 32'h7FFF_FFFF, 8'($urandom));
  endtask

  // Receiver: random stalls, ready stretches, and one long hold on request.
  initial begin : rx_side
    int   stall_left;
    int   calm_left;
    int   r;
    logic held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx && !held) begin
        held     = 1'b1;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (calm_left > 0) begin
        m_tready <= 1'b1;
        calm_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(99);
        if (r < 4) calm_left = $urandom_range(80, 20);
        else if (r < 10) stall_left = $urandom_range(40, 10);
        else if (r < 35) stall_left = $urandom_range(3, 1);
        m_tready <= (stall_left == 0);
      end
    end
  end

  initial begin : stimulus
    int   pick;
    logic hold_done;
    logic drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    send_cmd(OP_TICK, 32'd0, 8'h00);             // empty queue, nothing fires
    send_cmd(OP_LOAD, 32'h7FFF_FFFF, 8'hFF);
    send_cmd(OP_TICK, 32'hFFFF_FFFF, 8'h00);     // overflow up, saturates high
    send_cmd(OP_LOAD, 32'h8000_0000, 8'h00);
    send_cmd(OP_TICK, 32'd1, 8'h00);             // overflow down, saturates low
    send_cmd(OP_MINS, 32'h7FFF_FFFF, 8'h00);     // minutes overflow, both signs
    send_cmd(OP_MINS, 32'h8000_0000, 8'h00);
    send_cmd(OP_MINS, 32'd1024, 8'h00);          // 1024 minutes -> 61440
    send_cmd(OP_PAUSE, 32'd0, 8'h00);
    send_cmd(OP_TICK, 32'd500, 8'h00);           // paused tick leaves countdown
    send_cmd(OP_PAUSE, 32'd0, 8'h00);
    send_cmd(OP_ADD, 32'd30000, 8'h01);
    send_cmd(OP_ADD, 32'd30000, 8'h02);          // equal time goes ahead of id 1
    send_cmd(OP_ADD, 32'd50000, 8'hFF);
    send_cmd(OP_ADD, 32'h8000_0000, 8'h00);
    send_cmd(OP_ADD, 32'h7FFF_FFFF, 8'h80);
    send_cmd(OP_TICK, 32'd31440, 8'h00);         // lands on 30000, four fire
    send_cmd(OP_TICK, 32'h7FFF_FFFF, 8'h00);
    send_cmd(OP_TICK, 32'h7FFF_FFFF, 8'h00);     // floor reached, lowest fires
    send_cmd(3'd5, $urandom, 8'($urandom));      // undefined op codes
    send_cmd(3'd6, $urandom, 8'($urandom));
    send_cmd(3'd7, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(OP_LOAD, 32'd0, 8'h00);

    // --- random ---
    pick = sent;
    while (sent < pick + RAND_ITEMS) begin
      if (!hold_done && sent >= pick + 100) begin
        hold_rx   = 1'b1;   // sender keeps offering through the hold
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= pick + 200) begin
        drain();
        drain_done = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2, 3: countdown_run();
        4, 5:       fill_and_flush();
        default:    send_cmd(3'($urandom_range(7)), $urandom, 8'($urandom));
      endcase
      if ($urandom_range(9) == 0) drain();
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("countdown_event_scheduler: match");
    end else begin
      $display("countdown_event_scheduler: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10ms;
    $display("countdown_event_scheduler: mismatch");
    $finish;
  end

endmodule
